### rtl/buoyancy_drag_force_unit_assert.svh
// Assertion macros for the buoyancy and drag force unit.
`ifndef BUOYANCY_DRAG_FORCE_UNIT_ASSERT_SVH
`define BUOYANCY_DRAG_FORCE_UNIT_ASSERT_SVH

// clocked check with reset disable
`define BDF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define BDF_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bdf_pkg.sv
// Shared types and constants for the buoyancy and drag force unit.
package bdf_pkg;

    localparam logic [1:0] SHAPE_BOX     = 2'd0;
    localparam logic [1:0] SHAPE_SPHERE  = 2'd1;
    localparam logic [1:0] SHAPE_CAPSULE = 2'd2;
    localparam logic [1:0] SHAPE_NONE    = 2'd3;

    localparam logic [1:0] CFG_GRAVITY  = 2'd0;
    localparam logic [1:0] CFG_STRENGTH = 2'd1;
    localparam logic [1:0] CFG_DRAG     = 2'd2;

    localparam logic [30:0] GRAVITY_RST  = 31'd642908;
    localparam logic [30:0] STRENGTH_RST = 31'd65536;
    localparam logic [30:0] DRAG_RST     = 31'd65536;
    localparam logic [31:0] Q_HALF       = 32'd32768;

    localparam int DIV_STAGES = 17;
    localparam int QDEPTH     = 4;

    typedef struct packed {
        logic        skip;
        logic [16:0] ratio;
        logic [30:0] mass;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

### rtl/bdf_front.sv
// Front end: half height, depth clamp and pipelined submersion ratio divider.
module bdf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_body_static,
    input  logic [1:0]         i_collider_shape,
    input  logic [30:0]        i_size_x,
    input  logic [30:0]        i_size_y,
    input  logic [30:0]        i_capsule_length,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_water_height,
    input  logic [30:0]        i_mass,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  bdf_pkg::t_qstat    i_qstat,
    output logic               o_push,
    output bdf_pkg::t_item     o_item
);
    import bdf_pkg::*;

    localparam int LAST = DIV_STAGES;

    logic        r_v    [0:LAST];
    logic        r_skip [0:LAST];
    logic [32:0] r_full [0:LAST];
    logic [32:0] r_rem  [0:LAST];
    logic [16:0] r_q    [0:LAST];
    logic [30:0] r_mass [0:LAST];
    logic [31:0] r_vx   [0:LAST];
    logic [31:0] r_vy   [0:LAST];
    logic [31:0] r_vz   [0:LAST];

    logic               en;
    logic [31:0]        half;
    logic [32:0]        full;
    logic signed [33:0] depth_s;
    logic [32:0]        depth;

    assign en      = !r_v[LAST] || !i_qstat.full;
    assign o_stall = !en;
    assign o_push  = r_v[LAST] && !i_qstat.full;

    always_comb begin
        unique case (i_collider_shape)
            SHAPE_BOX:     half = {1'b0, i_size_y};
            SHAPE_SPHERE:  half = {1'b0, i_size_x};
            SHAPE_CAPSULE: half = {1'b0, i_size_x} + {2'b0, i_capsule_length[30:1]};
            default:       half = Q_HALF;
        endcase
        full    = {half, 1'b0};
        depth_s = {{2{i_water_height[31]}}, i_water_height}
                - {{2{i_pos_y[31]}}, i_pos_y} + {2'b0, half};
        if (depth_s[33]) begin
            depth = '0;
        end else if (depth_s[32:0] > full) begin
            depth = full;
        end else begin
            depth = depth_s[32:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
        end
        if (en) begin
            r_skip[0] <= i_body_static || (full == '0);
            r_full[0] <= full;
            r_rem[0]  <= depth;
            r_q[0]    <= '0;
            r_mass[0] <= i_mass;
            r_vx[0]   <= i_vel_x;
            r_vy[0]   <= i_vel_y;
            r_vz[0]   <= i_vel_z;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 1; k <= LAST; k++) begin : g_div
        logic [33:0] rem_in;
        logic        ge;
        logic [33:0] rem_sub;

        if (k == 1) begin : g_first
            assign rem_in = {1'b0, r_rem[k-1]};
        end else begin : g_rest
            assign rem_in = {r_rem[k-1], 1'b0};
        end
        assign ge      = rem_in >= {1'b0, r_full[k-1]};
        assign rem_sub = ge ? rem_in - {1'b0, r_full[k-1]} : rem_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en) begin
                r_v[k] <= r_v[k-1];
            end
            if (en) begin
                r_skip[k] <= r_skip[k-1];
                r_full[k] <= r_full[k-1];
                r_rem[k]  <= rem_sub[32:0];
                r_q[k]    <= {r_q[k-1][15:0], ge};
                r_mass[k] <= r_mass[k-1];
                r_vx[k]   <= r_vx[k-1];
                r_vy[k]   <= r_vy[k-1];
                r_vz[k]   <= r_vz[k-1];
            end
        end
    end

    assign o_item.skip  = r_skip[LAST] || (r_q[LAST] == '0);
    assign o_item.ratio = r_q[LAST];
    assign o_item.mass  = r_mass[LAST];
    assign o_item.vel_x = r_vx[LAST];
    assign o_item.vel_y = r_vy[LAST];
    assign o_item.vel_z = r_vz[LAST];

endmodule

### rtl/bdf_queue.sv
// Short queue between the ratio front end and the force back end.
module bdf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bdf_pkg::t_item  i_item,
    input  logic            i_pop,
    output bdf_pkg::t_item  o_head,
    output bdf_pkg::t_qstat o_qstat
);
    import bdf_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    t_item        r_mem [0:QDEPTH-1];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;

    assign o_head        = r_mem[r_rd];
    assign o_qstat.full  = r_cnt == (AW+1)'(QDEPTH);
    assign o_qstat.empty = r_cnt == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

### rtl/bdf_back.sv
// Back end: lift and drag products, saturation and output register.
module bdf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [30:0]        i_gravity,
    input  logic [30:0]        i_strength,
    input  logic [30:0]        i_drag,
    input  bdf_pkg::t_item     i_head,
    input  bdf_pkg::t_qstat    i_qstat,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_applied,
    output logic signed [31:0] o_lift_force,
    output logic signed [31:0] o_drag_x,
    output logic signed [31:0] o_drag_y,
    output logic signed [31:0] o_drag_z
);
    import bdf_pkg::*;

    logic r_v [0:3];
    logic en;

    // stage 1
    logic        r1_skip;
    logic [16:0] r1_ratio;
    logic [30:0] r1_mass;
    logic [61:0] r1_p;
    logic [47:0] r1_kd;
    logic [31:0] r1_av [0:2];
    logic        r1_neg [0:2];
    // stage 2
    logic        r2_skip;
    logic [62:0] r2_p;
    logic [61:0] r2_pk;
    logic [31:0] r2_av [0:2];
    logic        r2_neg [0:2];
    // stage 3
    logic        r3_skip;
    logic [53:0] r3_lhi;
    logic [53:0] r3_llo;
    logic [54:0] r3_dhi [0:2];
    logic [54:0] r3_dlo [0:2];
    logic        r3_neg [0:2];

    logic [31:0] vin [0:2];
    logic [45:0] lift2;
    logic [45:0] kk;
    logic [76:0] lsum;
    logic [77:0] dsum [0:2];
    logic [31:0] dres [0:2];
    logic [31:0] lres;

    assign en      = !r_v[3] || !i_stall;
    assign o_pop   = en && !i_qstat.empty;
    assign o_valid = r_v[3];

    assign vin[0] = i_head.vel_x;
    assign vin[1] = i_head.vel_y;
    assign vin[2] = i_head.vel_z;
    assign lift2  = r2_p[61:16];
    assign kk     = r2_pk[61:16];
    assign lsum   = {r3_lhi, 23'b0} + 77'(r3_llo);
    assign lres   = (|lsum[76:47]) ? 32'h7FFF_FFFF : {1'b0, lsum[46:16]};

    for (genvar a = 0; a < 3; a++) begin : g_ax
        assign dsum[a] = {r3_dhi[a], 23'b0} + 78'(r3_dlo[a]);
        always_comb begin
            if (r3_neg[a]) begin
                dres[a] = (|dsum[a][77:47]) ? 32'h7FFF_FFFF : {1'b0, dsum[a][46:16]};
            end else begin
                dres[a] = (|dsum[a][77:47]) ? 32'h8000_0000
                                            : 32'd0 - {1'b0, dsum[a][46:16]};
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r1_neg[a] <= vin[a][31];
                r1_av[a]  <= vin[a][31] ? 32'd0 - vin[a] : vin[a];
                r2_neg[a] <= r1_neg[a];
                r2_av[a]  <= r1_av[a];
                r3_neg[a] <= r2_neg[a];
                r3_dhi[a] <= 55'(kk[45:23]) * 55'(r2_av[a]);
                r3_dlo[a] <= 55'(kk[22:0]) * 55'(r2_av[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
            r_v[1] <= 1'b0;
            r_v[2] <= 1'b0;
            r_v[3] <= 1'b0;
        end else if (en) begin
            r_v[0] <= o_pop;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
        end
        if (en) begin
            r1_skip  <= i_head.skip;
            r1_ratio <= i_head.ratio;
            r1_mass  <= i_head.mass;
            r1_p     <= 62'(i_head.mass) * 62'(i_gravity);
            r1_kd    <= 48'(i_drag) * 48'(i_head.ratio);

            r2_skip  <= r1_skip;
            r2_p     <= 63'(r1_p[61:16]) * 63'(r1_ratio);
            r2_pk    <= 62'(r1_kd[46:16]) * 62'(r1_mass);

            r3_skip  <= r2_skip;
            r3_lhi   <= 54'(lift2[45:23]) * 54'(i_strength);
            r3_llo   <= 54'(lift2[22:0]) * 54'(i_strength);

            o_applied    <= !r3_skip;
            o_lift_force <= r3_skip ? '0 : lres;
            o_drag_x     <= r3_skip ? '0 : dres[0];
            o_drag_y     <= r3_skip ? '0 : dres[1];
            o_drag_z     <= r3_skip ? '0 : dres[2];
        end
    end

endmodule

### rtl/buoyancy_drag_force_unit.sv
// Buoyancy and drag force unit: top level with configuration registers.
// Usage:
//   Input channel i_in_valid / o_in_stall carries one body per transfer;
//   output channel o_out_valid / i_out_stall returns one result per body,
//   in order. Configuration registers are written through i_cfg_we,
//   i_cfg_idx and i_cfg_data while the unit is idle; unknown indexes are
//   ignored.
//   From input transfer to result, a body passes depth clamping, the
//   one-bit-per-stage ratio divider, the queue and the multiplier
//   pipeline. One body is accepted per cycle while o_in_stall is low;
//   throughput is one result per cycle while i_out_stall is low.
//   A stalled output freezes the back end; the queue absorbs work in
//   flight and the front end stalls its input only once the queue fills.
//   Synchronous reset empties the pipelines and queue and loads the
//   default gravity, buoyancy strength and drag coefficient.
module buoyancy_drag_force_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_body_static,
    input  logic [1:0]         i_collider_shape,
    input  logic [30:0]        i_size_x,
    input  logic [30:0]        i_size_y,
    input  logic [30:0]        i_capsule_length,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_water_height,
    input  logic [30:0]        i_mass,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_applied,
    output logic signed [31:0] o_lift_force,
    output logic signed [31:0] o_drag_x,
    output logic signed [31:0] o_drag_y,
    output logic signed [31:0] o_drag_z
);
    import bdf_pkg::*;

    logic [30:0] r_gravity;
    logic [30:0] r_strength;
    logic [30:0] r_drag;

    t_item  push_item;
    t_item  head;
    t_qstat qstat;
    logic   push;
    logic   pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity  <= GRAVITY_RST;
            r_strength <= STRENGTH_RST;
            r_drag     <= DRAG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRAVITY:  r_gravity  <= i_cfg_data;
                CFG_STRENGTH: r_strength <= i_cfg_data;
                CFG_DRAG:     r_drag     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bdf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_stall          (o_in_stall),
        .i_body_static    (i_body_static),
        .i_collider_shape (i_collider_shape),
        .i_size_x         (i_size_x),
        .i_size_y         (i_size_y),
        .i_capsule_length (i_capsule_length),
        .i_pos_y          (i_pos_y),
        .i_water_height   (i_water_height),
        .i_mass           (i_mass),
        .i_vel_x          (i_vel_x),
        .i_vel_y          (i_vel_y),
        .i_vel_z          (i_vel_z),
        .i_qstat          (qstat),
        .o_push           (push),
        .o_item           (push_item)
    );

    bdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    bdf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_gravity    (r_gravity),
        .i_strength   (r_strength),
        .i_drag       (r_drag),
        .i_head       (head),
        .i_qstat      (qstat),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_applied    (o_applied),
        .o_lift_force (o_lift_force),
        .o_drag_x     (o_drag_x),
        .o_drag_y     (o_drag_y),
        .o_drag_z     (o_drag_z)
    );

endmodule

### rtl/bdf_checker.sv
// Port-level checks for the buoyancy and drag force unit, bound to the top level.
`include "buoyancy_drag_force_unit_assert.svh"
module bdf_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_applied,
    input logic signed [31:0] o_lift_force,
    input logic signed [31:0] o_drag_x,
    input logic signed [31:0] o_drag_y,
    input logic signed [31:0] o_drag_z
);

    `BDF_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "result dropped while stalled")
    `BDF_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable(o_lift_force) && $stable(o_drag_x) && $stable(o_applied), "stalled result changed")
    `BDF_ASSERT(a_skip_zero, i_clk, i_rst_n, o_out_valid && !o_applied |-> o_lift_force == 0 && o_drag_x == 0 && o_drag_y == 0 && o_drag_z == 0, "skipped body has nonzero force")
    `BDF_ASSERT(a_lift_pos, i_clk, i_rst_n, o_out_valid && o_applied |-> !o_lift_force[31], "negative lift")
    `BDF_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind buoyancy_drag_force_unit bdf_port_checker u_bdf_checker (.*);
